### sv/saq_pkg.sv
// Shared types and constants of the sorted alarm queue.
package saq_pkg;

	// Most results that one input item may cause
	localparam int MAX_RESULTS = 16;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	typedef logic [RES_CNT_W-1:0] res_cnt_t;

	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_START  = 2'd1,
		ACT_CANCEL = 2'd2,
		ACT_CREATE = 2'd3
	} action_t;

	typedef struct packed {
		action_t     action;
		logic [3:0]  timer_id;
		logic [15:0] interval;
	} in_item_t;

	typedef struct packed {
		logic [3:0] fired_id;
		logic       overflow;
		logic       last_of_run;
	} out_item_t;

	// Operation broadcast to every cell of the row
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_CMP  = 2'd1,
		CELL_INS  = 2'd2,
		CELL_POP  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t   op;
		logic [3:0] slot;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_CMP  = 3'd1,
		ST_INS  = 3'd2,
		ST_POP  = 3'd3,
		ST_DONE = 3'd4
	} state_t;

endpackage

### sv/saq_cell.sv
// One queue cell: holds a deadline and slot, shifts to or from its neighbors.
module saq_cell import saq_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctrl_t           ctrl,
	input  logic [TIME_BITS-1:0] key,
	input  logic                 occ,
	input  logic [TIME_BITS-1:0] left_dl,
	input  logic [3:0]           left_slot,
	input  logic [TIME_BITS-1:0] right_dl,
	input  logic [3:0]           right_slot,
	input  logic                 chain_in,
	output logic                 chain_out,
	output logic [TIME_BITS-1:0] dl,
	output logic [3:0]           slot
);

	logic [TIME_BITS-1:0] dl_q;
	logic [3:0]           slot_q;
	logic                 flag_q;
	logic [TIME_BITS-1:0] diff;
	logic                 is_earlier;

	// Stored deadline is strictly earlier than the key (wrapping compare)
	always_comb begin
		diff       = dl_q - key;
		is_earlier = diff[TIME_BITS-1];
	end

	// This cell and every cell to its left hold an earlier deadline
	assign chain_out = chain_in & flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctrl.op == CELL_CMP) begin
			flag_q <= occ & is_earlier;
		end
	end

	// Insert: first later cell takes the key, cells past it the left entry; pop: all take the right
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_INS: begin
				if (!chain_in) begin
					dl_q   <= left_dl;
					slot_q <= left_slot;
				end else if (!flag_q) begin
					dl_q   <= key;
					slot_q <= ctrl.slot;
				end
			end
			CELL_POP: begin
				dl_q   <= right_dl;
				slot_q <= right_slot;
			end
			default: ;
		endcase
	end

	assign dl   = dl_q;
	assign slot = slot_q;

endmodule

### sv/sorted_alarm_queue_core.sv
// Top level of the sorted alarm queue: control, time counter, cell row, output stage.
// Sequence: a tick goes to the pop state, a start with room through compare, insert and pop,
//   a start on a full queue straight to done as an overflow; a result waits in the holding
//   register until the next one is found or the item closes.
// A new item is taken only in idle; a cancel or create stays in idle. Due entries pop one
//   per cycle (single front-cell pop) unless an active one waits on an output stall.
// Reset: queue empty, time zero, all timer slots active; no clearing pass.
module sorted_alarm_queue_core import saq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TIMER_SLOTS = 16,
	parameter int TIME_BITS   = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOT_W = $clog2(TIMER_SLOTS);

	state_t               state_q, state_nxt;
	logic [CNT_W-1:0]     count_q;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] key_q;
	logic [3:0]           id_q;
	logic                 active_q [TIMER_SLOTS];
	res_cnt_t             emit_cnt_q;
	logic                 pend_v_q;
	out_item_t            pend_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic [TIME_BITS-1:0] cell_dl   [QUEUE_DEPTH];
	logic [3:0]           cell_slot [QUEUE_DEPTH];
	logic                 chain     [QUEUE_DEPTH+1];
	cell_ctrl_t           ctrl;

	logic                 accept, in_range, out_free;
	logic [TIME_BITS-1:0] front_diff;
	logic                 front_due, front_act, can_pop;
	logic                 do_pop, emit, move_pend, move_last;

	// Input decode
	assign accept   = in_valid & in_ready;
	assign in_range = 32'(in_data.timer_id) < TIMER_SLOTS;
	assign out_free = !out_valid_q || out_ready;

	// Front entry due check and slot activity
	always_comb begin
		front_diff = cell_dl[0] - now_q;
		front_due  = (count_q != '0) && ((front_diff == '0) || front_diff[TIME_BITS-1]);
		front_act  = active_q[SLOT_W'(cell_slot[0])];
		can_pop    = front_due && (emit_cnt_q < res_cnt_t'(MAX_RESULTS));
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_data.action)
						ACT_TICK:  state_nxt = ST_POP;
						ACT_START: begin
							if (in_range) begin
								state_nxt = (count_q == CNT_W'(QUEUE_DEPTH)) ? ST_DONE : ST_CMP;
							end
						end
						default: ;
					endcase
				end
			end
			ST_CMP:  state_nxt = ST_INS;
			ST_INS:  state_nxt = ST_POP;
			ST_POP:  if (!can_pop) state_nxt = ST_DONE;
			ST_DONE: if (!pend_v_q || out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		in_ready  = 1'b0;
		ctrl.op   = CELL_HOLD;
		ctrl.slot = id_q;
		do_pop    = 1'b0;
		emit      = 1'b0;
		move_pend = 1'b0;
		move_last = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_CMP:  ctrl.op = CELL_CMP;
			ST_INS:  ctrl.op = CELL_INS;
			ST_POP: begin
				if (can_pop) begin
					if (!front_act) begin
						do_pop = 1'b1;
					end else if (!pend_v_q || out_free) begin
						// held result leaves as non-final, the new one takes its place
						do_pop    = 1'b1;
						emit      = 1'b1;
						move_pend = pend_v_q;
					end
				end
				if (do_pop) ctrl.op = CELL_POP;
			end
			ST_DONE: begin
				if (pend_v_q && out_free) begin
					move_pend = 1'b1;
					move_last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Row of cells
	assign chain[0] = 1'b1;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [TIME_BITS-1:0] l_dl, r_dl;
		logic [3:0]           l_slot, r_slot;
		if (i == 0) begin : g_first
			assign l_dl   = key_q;
			assign l_slot = id_q;
		end else begin : g_mid
			assign l_dl   = cell_dl[i-1];
			assign l_slot = cell_slot[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign r_dl   = cell_dl[i];
			assign r_slot = cell_slot[i];
		end else begin : g_inner
			assign r_dl   = cell_dl[i+1];
			assign r_slot = cell_slot[i+1];
		end
		saq_cell #(
			.TIME_BITS(TIME_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.key        (key_q),
			.occ        (CNT_W'(i) < count_q),
			.left_dl    (l_dl),
			.left_slot  (l_slot),
			.right_dl   (r_dl),
			.right_slot (r_slot),
			.chain_in   (chain[i]),
			.chain_out  (chain[i+1]),
			.dl         (cell_dl[i]),
			.slot       (cell_slot[i])
		);
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			now_q       <= '0;
			emit_cnt_q  <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int s = 0; s < TIMER_SLOTS; s++) active_q[s] <= 1'b1;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				emit_cnt_q <= '0;
				if (in_data.action == ACT_TICK) begin
					now_q <= now_q + {{(TIME_BITS-1){1'b0}}, 1'b1};
				end else if (in_range) begin
					case (in_data.action)
						ACT_CANCEL: active_q[SLOT_W'(in_data.timer_id)] <= 1'b0;
						ACT_CREATE: active_q[SLOT_W'(in_data.timer_id)] <= 1'b1;
						ACT_START:  if (count_q == CNT_W'(QUEUE_DEPTH)) pend_v_q <= 1'b1;
						default: ;
					endcase
				end
			end
			if (state_q == ST_INS) count_q <= count_q + CNT_W'(1);
			else if (do_pop) count_q <= count_q - CNT_W'(1);
			if (emit) begin
				emit_cnt_q <= emit_cnt_q + res_cnt_t'(1);
				pend_v_q   <= 1'b1;
			end else if (move_pend) begin
				pend_v_q <= 1'b0;
			end
			if (move_pend) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= now_q + {{(TIME_BITS-16){1'b0}}, in_data.interval};
			id_q  <= in_data.timer_id;
			pend_q.fired_id    <= in_data.timer_id;
			pend_q.overflow    <= 1'b1;
			pend_q.last_of_run <= 1'b0;
		end else if (emit) begin
			pend_q.fired_id    <= cell_slot[0];
			pend_q.overflow    <= 1'b0;
			pend_q.last_of_run <= 1'b0;
		end
		if (move_pend) begin
			out_q.fired_id    <= pend_q.fired_id;
			out_q.overflow    <= pend_q.overflow;
			out_q.last_of_run <= move_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Insertion point always falls inside the row
	a_ins_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INS |-> !chain[QUEUE_DEPTH])
		else $error("insert point beyond last cell");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_emit_limit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_cnt_q <= res_cnt_t'(MAX_RESULTS))
		else $error("too many results for one item");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !pend_v_q)
		else $error("held result while idle");

	a_final_marked: assert property (@(posedge clk) disable iff (!arst_n)
		move_last |=> out_valid_q && out_q.last_of_run)
		else $error("final result not marked");

endmodule

### tb/sorted_alarm_queue_core_tb.sv
// Self-checking testbench of the sorted alarm queue: directed table, random traffic, predictor.
module sorted_alarm_queue_core_tb;
	import saq_pkg::*;

	localparam int QDEPTH           = 16;
	localparam int SLOTS            = 16;
	localparam int RANDOM_ITEMS     = 155;
	localparam int DRAIN_AT         = 90;
	localparam int SINK_HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES      = 40;
	localparam int CYCLE_LIMIT      = 200000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	sorted_alarm_queue_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Directed stimulus row; typed rows carry their expected results
	typedef struct {
		in_item_t  item;
		bit        typed;
		int        n_exp;
		out_item_t res;
	} dir_row_t;

	dir_row_t  dir_rows[$];
	out_item_t alarm_due_q[$];   // alarms and overflows still to come out
	out_item_t step_alarms[$];   // results of the item being predicted

	// Predictor state
	logic [31:0] pq_deadline [QDEPTH];
	logic [3:0]  pq_slot [QDEPTH];
	int          pq_count;
	logic [31:0] pq_now;
	logic [SLOTS-1:0] slot_active;

	int  mismatches;
	int  items_sent;
	int  fired_seen;
	int  overflow_seen;
	int  cycle_cnt;
	bit  sink_hold_req;

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog
	initial cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, alarm_due_q.size());
			$display("sorted_alarm_queue_core_tb: done, errors");
			$finish;
		end
	end

	// a earlier than b by signed difference
	function automatic bit deadline_earlier(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	// Pop due front entries, at most MAX_RESULTS emissions per item
	function automatic void pop_due_alarms();
		logic [31:0] d;
		logic [3:0]  s;
		out_item_t   res;
		while (pq_count > 0 && step_alarms.size() < MAX_RESULTS) begin
			d = pq_deadline[0] - pq_now;
			if (!(d == 32'd0 || d[31]))
				break;
			s = pq_slot[0];
			for (int i = 0; i < pq_count - 1; i++) begin
				pq_deadline[i] = pq_deadline[i+1];
				pq_slot[i]     = pq_slot[i+1];
			end
			pq_count--;
			if (slot_active[s]) begin
				res.fired_id    = s;
				res.overflow    = 1'b0;
				res.last_of_run = 1'b0;
				step_alarms.insert(step_alarms.size(), res);
			end
		end
	endfunction

	// Predict the results of one accepted item into step_alarms
	function automatic void predict_alarms(in_item_t it);
		logic [31:0] dl;
		int pos;
		out_item_t res;
		step_alarms.delete();
		case (it.action)
			ACT_TICK: begin
				pq_now = pq_now + 32'd1;
				pop_due_alarms();
			end
			ACT_CANCEL: slot_active[it.timer_id] = 1'b0;
			ACT_CREATE: slot_active[it.timer_id] = 1'b1;
			default: begin
				dl = pq_now + {16'd0, it.interval};
				if (pq_count >= QDEPTH) begin
					res.fired_id    = it.timer_id;
					res.overflow    = 1'b1;
					res.last_of_run = 1'b0;
					step_alarms.insert(step_alarms.size(), res);
				end else begin
					pos = 0;
					while (pos < pq_count && deadline_earlier(pq_deadline[pos], dl))
						pos++;
					for (int i = pq_count; i > pos; i--) begin
						pq_deadline[i] = pq_deadline[i-1];
						pq_slot[i]     = pq_slot[i-1];
					end
					pq_deadline[pos] = dl;
					pq_slot[pos]     = it.timer_id;
					pq_count++;
					pop_due_alarms();
				end
			end
		endcase
		if (step_alarms.size() > 0)
			step_alarms[step_alarms.size()-1].last_of_run = 1'b1;
	endfunction

	function automatic void add_row(action_t act, int id, int ivl, bit typed, int n, bit ovf);
		dir_row_t r;
		r.item  = '{action: act, timer_id: id[3:0], interval: ivl[15:0]};
		r.typed = typed;
		r.n_exp = n;
		r.res   = '{fired_id: id[3:0], overflow: ovf, last_of_run: 1'b1};
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	// Random item: mostly ticks and short alarms, few long ones that linger
	function automatic in_item_t rand_alarm_item();
		in_item_t it;
		int r;
		int k;
		r = $urandom_range(0, 99);
		it.timer_id = 4'($urandom_range(0, SLOTS - 1));
		it.interval = 16'($urandom());
		if (r < 40) begin
			it.action = ACT_TICK;
		end else if (r < 75) begin
			it.action = ACT_START;
			k = $urandom_range(0, 39);
			if (k == 1)
				it.interval = 16'd0;
			else if (k != 0)
				it.interval = 16'($urandom_range(0, 12));
		end else if (r < 87) begin
			it.action = ACT_CANCEL;
		end else begin
			it.action = ACT_CREATE;
		end
		return it;
	endfunction

	// Offer one item and hold it until accepted
	task automatic send_item(in_item_t it);
		in_data  <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Result check against the oldest expectation
	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (out_data.overflow)
				overflow_seen++;
			else
				fired_seen++;
			if (alarm_due_q.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: id %0d ovf %0b last %0b",
						out_data.fired_id, out_data.overflow, out_data.last_of_run);
				mismatches++;
			end else begin
				want = alarm_due_q[0];
				alarm_due_q.delete(0);
				if (out_data.fired_id !== want.fired_id ||
				    out_data.overflow !== want.overflow ||
				    out_data.last_of_run !== want.last_of_run) begin
					if (mismatches < 10)
						$display("mismatch: exp id %0d ovf %0b last %0b, got id %0d ovf %0b last %0b",
							want.fired_id, want.overflow, want.last_of_run,
							out_data.fired_id, out_data.overflow, out_data.last_of_run);
					mismatches++;
				end
			end
		end
	end

	// Receiver: ready pattern in modes of random length, one long hold-off on request
	initial begin : sink
		int mode;
		int left;
		out_ready <= 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(5, 60);
			end
			left--;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Main sequence
	initial begin : main_seq
		in_item_t it;
		int burst_left;
		int n_dir;
		arst_n        = 1'b0;
		in_valid      <= 1'b0;
		in_data       <= '0;
		sink_hold_req = 1'b0;
		mismatches    = 0;
		items_sent    = 0;
		fired_seen    = 0;
		overflow_seen = 0;
		pq_count      = 0;
		pq_now        = '0;
		slot_active   = '1;
		burst_left    = 0;

		// Directed table
		add_row(ACT_TICK,   0,  0,      1, 0, 0);  // tick on empty queue
		add_row(ACT_START,  3,  0,      1, 1, 0);  // zero interval fires at once
		add_row(ACT_CANCEL, 3,  'hFFFF, 1, 0, 0);
		add_row(ACT_START,  3,  0,      1, 0, 0);  // popped on a cancelled slot: dropped
		add_row(ACT_CREATE, 3,  0,      1, 0, 0);
		for (int i = 0; i < QDEPTH; i++)
			add_row(ACT_START, i, 2, 0, 0, 0);     // fill queue with one deadline
		add_row(ACT_START,  7,  'hFFFF, 1, 1, 1);  // full queue: overflow
		add_row(ACT_CANCEL, 9,  'h5A5A, 0, 0, 0);
		add_row(ACT_TICK,   0,  'hA5A5, 0, 0, 0);
		add_row(ACT_TICK,   15, 0,      0, 0, 0);  // many due at once
		add_row(ACT_CREATE, 9,  0,      0, 0, 0);
		add_row(ACT_CREATE, 15, 'hFFFF, 1, 0, 0);
		n_dir = dir_rows.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < n_dir; r++) begin
			send_item(dir_rows[r].item);
			predict_alarms(dir_rows[r].item);
			if (dir_rows[r].typed) begin
				if (dir_rows[r].n_exp > 0)
					alarm_due_q.insert(alarm_due_q.size(), dir_rows[r].res);
			end else begin
				foreach (step_alarms[j])
					alarm_due_q.insert(alarm_due_q.size(), step_alarms[j]);
			end
		end

		// Random traffic; receiver parks at the start so the block backs up
		sink_hold_req = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			it = rand_alarm_item();
			send_item(it);
			predict_alarms(it);
			foreach (step_alarms[j])
				alarm_due_q.insert(alarm_due_q.size(), step_alarms[j]);
			if (n == DRAIN_AT) begin
				// sender waits for every outstanding result
				in_valid <= 1'b0;
				do @(posedge clk); while (alarm_due_q.size() != 0);
			end else if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(1, 10);
			end else begin
				burst_left--;
			end
		end
		in_valid <= 1'b0;

		// Drain and let the block settle
		while (alarm_due_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d items (%0d directed): %0d alarms fired, %0d overflows",
			items_sent, n_dir, fired_seen, overflow_seen);
		$display("mismatches: %0d, cycles: %0d", mismatches, cycle_cnt);
		if (mismatches == 0 && alarm_due_q.size() == 0)
			$display("sorted_alarm_queue_core_tb: done, clean");
		else
			$display("sorted_alarm_queue_core_tb: done, errors");
		$finish;
	end

endmodule
